// ----- hdl/gpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Gamepad poll decoder package
// Shared widths, register indexes, bit maps and decode helpers.
// ----------------------------------------------------------------------------
package gpd_pkg;

    localparam int GENESIS_READS = 8;
    localparam int SNES_READS    = 16;
    localparam int POLL_LEN      = GENESIS_READS + SNES_READS;
    localparam int COUNT_W       = 5;
    localparam int NUM_PADS      = 4;
    localparam int NUM_KEYS      = 12;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_GENESIS_A = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_GENESIS_B = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_SNES_A    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_SNES_B    = 8'd3;

    localparam logic [COUNT_W-1:0] LAST_SAMPLE = COUNT_W'(POLL_LEN - 1);
    localparam logic [COUNT_W-1:0] GEN_SAMPLES = COUNT_W'(GENESIS_READS);

    // Genesis state word: eight six-bit entries, one per Genesis read.
    typedef logic [GENESIS_READS-1:0][5:0] t_gen_accum;
    typedef logic [SNES_READS-1:0]         t_snes_accum;

    // Raw (active-low) key levels in the common key order plus the disconnect bit.
    typedef struct packed {
        logic [NUM_KEYS-1:0] keys;
        logic                disc;
    } t_pad_level;

    typedef struct packed {
        logic [NUM_KEYS-1:0] pressed_keys;
        logic [NUM_KEYS-1:0] changed_keys;
        logic                connected;
        logic                plug_event;
        logic                keys_reported;
        logic                six_button;
    } t_pad_result;

    localparam logic [5:0] GEN_BITS [NUM_KEYS] = '{
        6'd59, 6'd58, 6'd49, 6'd48, 6'd60, 6'd52, 6'd53, 6'd61, 6'd17, 6'd18, 6'd19, 6'd16
    };
    localparam logic [3:0] SNES_BITS [NUM_KEYS] = '{
        4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd15, 4'd13, 4'd12, 4'd6, 4'd14, 4'd5, 4'd4
    };
    localparam logic [5:0] GEN_DISC_BIT = 6'd56;
    localparam logic [5:0] GEN_SIX_BIT  = 6'd8;

    function automatic logic gpd_gen_bit(input t_gen_accum acc, input logic [5:0] b);
        logic [5:0] byte_val;
        byte_val = acc[b[5:3]];
        return byte_val[b[2:0]];
    endfunction

    function automatic t_pad_level gpd_gen_level(input t_gen_accum acc);
        t_pad_level lv;
        for (int k = 0; k < NUM_KEYS; k++) begin
            lv.keys[k] = gpd_gen_bit(acc, GEN_BITS[k]);
        end
        lv.disc = gpd_gen_bit(acc, GEN_DISC_BIT);
        return lv;
    endfunction

    // An all-zero SNES word means the pad is unplugged: all keys released.
    function automatic t_pad_level gpd_snes_level(input t_snes_accum acc);
        t_pad_level lv;
        if (acc == '0) begin
            lv.keys = '1;
            lv.disc = 1'b1;
        end else begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                lv.keys[k] = acc[SNES_BITS[k]];
            end
            lv.disc = 1'b0;
        end
        return lv;
    endfunction

endpackage

// ----- hdl/gpd_in_if.sv -----
// ----------------------------------------------------------------------------
// Gamepad poll decoder sample channel
// Valid/ready channel carrying one sampled bus word per transfer.
// ----------------------------------------------------------------------------
interface gpd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_word;
    logic        read_error;

    modport source (output valid, output sample_word, output read_error, input ready);
    modport sink   (input valid, input sample_word, input read_error, output ready);
endinterface

// ----- hdl/gpd_out_if.sv -----
// ----------------------------------------------------------------------------
// Gamepad poll decoder result channel
// Valid/ready channel carrying one decoded pad state per transfer.
// ----------------------------------------------------------------------------
interface gpd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  pad_index;
    logic [11:0] pressed_keys;
    logic [11:0] changed_keys;
    logic        connected;
    logic        plug_event;
    logic        keys_reported;
    logic        six_button;
    logic        last_of_poll;

    modport source (
        output valid, output pad_index, output pressed_keys, output changed_keys,
        output connected, output plug_event, output keys_reported, output six_button,
        output last_of_poll, input ready
    );
    modport sink (
        input valid, input pad_index, input pressed_keys, input changed_keys,
        input connected, input plug_event, input keys_reported, input six_button,
        input last_of_poll, output ready
    );
endinterface

// ----- hdl/gpd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Gamepad poll decoder configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface gpd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [3:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/gpd_pad_decode.sv -----
// ----------------------------------------------------------------------------
// Gamepad pad decoder
// Turns raw key levels of one pad into pressed, changed and plug status.
// ----------------------------------------------------------------------------
module gpd_pad_decode
    import gpd_pkg::*;
(
    input  t_pad_level  i_level,
    input  t_pad_level  i_prev,
    input  logic        i_seen,
    input  logic        i_ext_en,
    input  logic        i_six,
    output t_pad_result o_result
);

    logic [NUM_KEYS-1:0] key_mask;

    // The four extra keys only count on pads that have them.
    assign key_mask = {{(NUM_KEYS-8){i_ext_en}}, 8'hff};

    always_comb begin
        o_result.pressed_keys  = ~i_level.keys & key_mask;
        o_result.changed_keys  = (i_level.keys ^ i_prev.keys) & key_mask & {NUM_KEYS{i_seen}};
        o_result.connected     = ~i_level.disc;
        o_result.plug_event    = ~i_seen | (i_level.disc ^ i_prev.disc);
        o_result.keys_reported = i_seen;
        o_result.six_button    = i_six;
    end

endmodule

// ----- hdl/gamepad_poll_decoder_core.sv -----
// ----------------------------------------------------------------------------
// Gamepad poll decoder core
// Decodes polls of two Genesis pads and two SNES pads from sampled bus words.
// ----------------------------------------------------------------------------
// Usage:
// - i_in takes one bus word per transfer. Words 0-7 of a poll fill the
//   Genesis pads, words 8-23 the SNES pads. A transfer with read_error set
//   aborts the poll and produces nothing.
// - The 24th word decodes all four pads in the same cycle into a four-entry
//   result buffer; o_out then presents pads 0, 1, 2, 3 on consecutive cycles
//   while ready is high, the first in the cycle after the final word; last_of_poll marks pad 3.
// - i_in accepts one word every cycle. The next poll fills while the buffer
//   drains; only the final word of a poll waits if the previous poll's
//   results are still buffered, so a stalled receiver backs up i_in there.
// - i_cfg writes an offset register (index 0-3); other indexes
//   are ignored. Write only while the block is idle.
// - Reset clears the offsets to their defaults, the poll progress and the
//   per-pad history, so the next poll reports a plug event on every pad.
// ----------------------------------------------------------------------------
module gamepad_poll_decoder_core
    import gpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    gpd_in_if.sink    i_in,
    gpd_cfg_if.sink   i_cfg,
    gpd_out_if.source o_out
);

    logic [3:0]         r_off_gen_a, r_off_gen_b, r_off_snes_a, r_off_snes_b;
    logic [COUNT_W-1:0] r_count, n_count;
    t_gen_accum         r_gen [2];
    t_gen_accum         n_gen [2];
    t_snes_accum        r_snes [2];
    t_snes_accum        n_snes [2];
    t_snes_accum        sh_snes [2];
    t_pad_level         r_prev [NUM_PADS];
    logic [NUM_PADS-1:0] r_seen;
    t_pad_result        r_res [NUM_PADS];
    logic               r_busy;
    logic [1:0]         r_idx;

    logic               in_acc, out_acc, out_done, poll_done;
    logic [15:0]        sh_a, sh_b;
    t_pad_level         level [NUM_PADS];
    logic               six [2];
    t_pad_result        res [NUM_PADS];

    assign i_cfg.ready = 1'b1;

    assign out_acc  = o_out.valid & o_out.ready;
    assign out_done = out_acc & (r_idx == 2'd3);
    assign i_in.ready = ~(r_busy & (r_count == LAST_SAMPLE) & ~out_done);
    assign in_acc   = i_in.valid & i_in.ready;

    assign sh_a = i_in.sample_word >> r_off_gen_a;
    assign sh_b = i_in.sample_word >> r_off_gen_b;
    assign sh_snes[0] = {r_snes[0][SNES_READS-2:0], i_in.sample_word[r_off_snes_a]};
    assign sh_snes[1] = {r_snes[1][SNES_READS-2:0], i_in.sample_word[r_off_snes_b]};

    assign poll_done = in_acc & ~i_in.read_error & (r_count == LAST_SAMPLE);

    always_comb begin
        n_count = r_count;
        n_gen   = r_gen;
        n_snes  = r_snes;
        if (in_acc) begin
            if (i_in.read_error || r_count == LAST_SAMPLE) begin
                n_count = '0;
                n_gen   = '{default: '0};
                n_snes  = '{default: '0};
            end else begin
                n_count = r_count + 1'b1;
                if (r_count < GEN_SAMPLES) begin
                    n_gen[0] = {r_gen[0][GENESIS_READS-2:0], sh_a[5:0]};
                    n_gen[1] = {r_gen[1][GENESIS_READS-2:0], sh_b[5:0]};
                end else begin
                    n_snes = sh_snes;
                end
            end
        end
    end

    // Decode all four pads from the state completed by the final word.
    always_comb begin
        level[0] = gpd_gen_level(r_gen[0]);
        level[1] = gpd_gen_level(r_gen[1]);
        level[2] = gpd_snes_level(sh_snes[0]);
        level[3] = gpd_snes_level(sh_snes[1]);
        six[0]   = gpd_gen_bit(r_gen[0], GEN_SIX_BIT);
        six[1]   = gpd_gen_bit(r_gen[1], GEN_SIX_BIT);
    end

    for (genvar p = 0; p < NUM_PADS; p++) begin : g_pad
        if (p < 2) begin : g_gen
            gpd_pad_decode u_dec (
                .i_level  (level[p]),
                .i_prev   (r_prev[p]),
                .i_seen   (r_seen[p]),
                .i_ext_en (six[p]),
                .i_six    (six[p]),
                .o_result (res[p])
            );
        end else begin : g_snes
            gpd_pad_decode u_dec (
                .i_level  (level[p]),
                .i_prev   (r_prev[p]),
                .i_seen   (r_seen[p]),
                .i_ext_en (1'b1),
                .i_six    (1'b0),
                .o_result (res[p])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_gen_a  <= 4'd0;
            r_off_gen_b  <= 4'd8;
            r_off_snes_a <= 4'd7;
            r_off_snes_b <= 4'd15;
            r_count      <= '0;
            r_gen        <= '{default: '0};
            r_snes       <= '{default: '0};
            r_seen       <= '0;
            r_busy       <= 1'b0;
            r_idx        <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_OFFSET_GENESIS_A: r_off_gen_a  <= i_cfg.data;
                    CFG_OFFSET_GENESIS_B: r_off_gen_b  <= i_cfg.data;
                    CFG_OFFSET_SNES_A:    r_off_snes_a <= i_cfg.data;
                    CFG_OFFSET_SNES_B:    r_off_snes_b <= i_cfg.data;
                    default: ;
                endcase
            end
            r_count <= n_count;
            r_gen   <= n_gen;
            r_snes  <= n_snes;
            if (poll_done) begin
                r_seen <= '1;
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (out_acc) begin
                r_idx <= r_idx + 1'b1;
                if (out_done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (poll_done) begin
            r_res  <= res;
            r_prev <= level;
        end
    end

    assign o_out.valid         = r_busy;
    assign o_out.pad_index     = r_idx;
    assign o_out.pressed_keys  = r_res[r_idx].pressed_keys;
    assign o_out.changed_keys  = r_res[r_idx].changed_keys;
    assign o_out.connected     = r_res[r_idx].connected;
    assign o_out.plug_event    = r_res[r_idx].plug_event;
    assign o_out.keys_reported = r_res[r_idx].keys_reported;
    assign o_out.six_button    = r_res[r_idx].six_button;
    assign o_out.last_of_poll  = (r_idx == 2'd3);

endmodule
